// ----- rtl/core/lzb_pkg.sv -----
// Shared types and constants for the LZ token context binarizer.
// Holds the channel payload structs, the token descriptor and the sequencer states.
// No dependencies.
`default_nettype none

package lzb_pkg;

	localparam int PROB_W   = 8;
	localparam int CTX_W    = 9;
	localparam int CTX_COUNT = 385;
	localparam int OFS_W    = 15;
	localparam int LEN_W    = 16;
	localparam int GAMMA_W  = 16;
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = 2;

	localparam logic [PROB_W-1:0] PROB_INIT  = 8'd128;
	localparam logic [CTX_W-1:0]  CTX_FLAG   = 9'd0;
	localparam logic [CTX_W-1:0]  CTX_TREE   = 9'd1;
	localparam logic [CTX_W-1:0]  CTX_REPEAT = 9'd256;
	localparam logic [CTX_W-1:0]  CTX_OFFSET = 9'd257;
	localparam logic [CTX_W-1:0]  CTX_LENGTH = 9'd321;
	localparam logic [CTX_W-1:0]  CTX_LAST   = 9'd384;

	typedef enum logic [1:0] {
		CMD_LITERAL = 2'd0,
		CMD_MATCH   = 2'd1,
		CMD_END     = 2'd2
	} lzb_cmd_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_LIT,
		SQ_REP,
		SQ_OFS,
		SQ_LEN
	} lzb_phase_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [7:0]       literal_byte;
		logic [OFS_W-1:0] match_offset;
		logic [LEN_W-1:0] match_length;
	} lzb_token_t;

	typedef struct packed {
		logic [PROB_W-1:0] step_probability;
		logic              step_bit;
		logic              last_step;
	} lzb_step_t;

	// One classified token, ready for the decision sequencer.
	typedef struct packed {
		lzb_cmd_t           kind;
		logic               emit_rep;
		logic               rep_bit;
		logic               code_ofs;
		logic [7:0]         lit;
		logic [GAMMA_W-1:0] ofs_val;
		logic [GAMMA_W-1:0] len_val;
	} lzb_desc_t;

endpackage

`default_nettype wire

// ----- rtl/core/lzb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module lzb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 385
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lzb_front.sv -----
// Front end: accepts tokens, tracks the repeat-offset state and classifies
// each token into a descriptor for the queue. Depends on lzb_pkg.
`default_nettype none

module lzb_front import lzb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       token_valid,
	output logic            token_stall,
	input  wire lzb_token_t token,
	input  wire logic       ready,
	input  wire logic       full,
	output logic            push,
	output lzb_desc_t       push_desc
);

	logic             prev_match_q;
	logic [OFS_W-1:0] recent_q;
	logic             accept;
	logic             known;
	logic             fresh;

	assign token_stall = !ready || full;
	assign accept      = token_valid && !token_stall;

	// A match codes a new offset when it follows a match or differs from the last one.
	assign fresh = prev_match_q || (token.match_offset != recent_q);

	always_comb begin
		known     = 1'b1;
		push_desc = '0;
		case (token.command)
			CMD_LITERAL: begin
				push_desc.kind = CMD_LITERAL;
				push_desc.lit  = token.literal_byte;
			end
			CMD_MATCH: begin
				push_desc.kind     = CMD_MATCH;
				push_desc.emit_rep = !prev_match_q;
				push_desc.rep_bit  = fresh;
				push_desc.code_ofs = fresh;
				push_desc.ofs_val  = {1'b0, token.match_offset} + 16'd1;
				push_desc.len_val  = token.match_length;
			end
			CMD_END: begin
				push_desc.kind     = CMD_END;
				push_desc.emit_rep = !prev_match_q;
				push_desc.rep_bit  = 1'b1;
				push_desc.code_ofs = 1'b1;
				push_desc.ofs_val  = 16'd1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign push = accept && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_match_q <= 1'b0;
			recent_q     <= '0;
		end else if (accept) begin
			if (token.command == CMD_LITERAL) begin
				prev_match_q <= 1'b0;
			end else if (token.command == CMD_MATCH) begin
				prev_match_q <= 1'b1;
				if (fresh) begin
					recent_q <= token.match_offset;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lzb_queue.sv -----
// Short descriptor queue between the front end and the decision sequencer.
// Depends on lzb_pkg.
`default_nettype none

module lzb_queue import lzb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire lzb_desc_t push_desc,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output lzb_desc_t      head
);

	lzb_desc_t          slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full       = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/core/lzb_back.sv -----
// Back end: sequences the binary decisions of each descriptor and runs the
// probability read-modify-write. Depends on lzb_pkg and lzb_ram.
`default_nettype none

module lzb_back import lzb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire lzb_desc_t head,
	output logic           pop,
	output logic           ready,
	output logic           step_valid,
	input  wire logic      step_stall,
	output lzb_step_t      step
);

	lzb_phase_t         phase_q, phase_d;
	lzb_desc_t          desc_q, desc_d;
	logic [CTX_W-1:0]   ctx_q, ctx_d;
	logic [GAMMA_W-1:0] val_q, val_d;
	logic               half_q, half_d;
	logic [7:0]         lit_q, lit_d;

	logic               have;
	logic               issue;
	logic               more;
	logic [CTX_W-1:0]   sel_ctx;
	logic               sel_bit;
	logic               sel_last;

	logic               clearing_q;
	logic [CTX_W-1:0]   clr_cnt_q;

	logic               valid_s1;
	logic [CTX_W-1:0]   ctx_s1;
	logic               bit_s1;
	logic               last_s1;
	logic               fwd_s1;
	logic               valid_s2;
	lzb_step_t          item_s2;

	logic               adv;
	logic               slot_free;
	logic [PROB_W-1:0]  rd_data;
	logic [PROB_W-1:0]  prob_cur;
	logic [PROB_W-1:0]  prob_new;
	logic [PROB_W-1:0]  last_p_q;
	logic [8:0]         delta;
	logic               wr_en;
	logic [CTX_W-1:0]   wr_addr;
	logic [PROB_W-1:0]  wr_data;

	assign ready      = !clearing_q;
	assign more       = |val_q[GAMMA_W-1:1];
	assign adv        = valid_s1 && (!valid_s2 || !step_stall);
	assign slot_free  = !valid_s1 || adv;
	assign step_valid = valid_s2;
	assign step       = item_s2;

	// Decision selected for this cycle.
	always_comb begin
		have     = 1'b0;
		sel_ctx  = CTX_FLAG;
		sel_bit  = 1'b0;
		sel_last = 1'b0;
		case (phase_q)
			SQ_IDLE: begin
				have    = head_valid;
				sel_bit = (head.kind != CMD_LITERAL);
			end
			SQ_LIT: begin
				have     = 1'b1;
				sel_ctx  = ctx_q;
				sel_bit  = lit_q[7];
				sel_last = ctx_q[7];
			end
			SQ_REP: begin
				have    = 1'b1;
				sel_ctx = CTX_REPEAT;
				sel_bit = desc_q.rep_bit;
			end
			SQ_OFS, SQ_LEN: begin
				have = 1'b1;
				if (more) begin
					sel_ctx = half_q ? (ctx_q + 9'd1) : ctx_q;
					sel_bit = half_q ? val_q[0] : 1'b1;
				end else begin
					sel_ctx  = ctx_q;
					sel_last = (phase_q == SQ_LEN) || (desc_q.kind != CMD_MATCH);
				end
			end
			default: begin
				have = 1'b0;
			end
		endcase
		issue = have && slot_free && !clearing_q;
		pop   = issue && (phase_q == SQ_IDLE);
	end

	// Sequencer next state.
	always_comb begin
		phase_d = phase_q;
		desc_d  = desc_q;
		ctx_d   = ctx_q;
		val_d   = val_q;
		half_d  = half_q;
		lit_d   = lit_q;
		if (issue) begin
			case (phase_q)
				SQ_IDLE: begin
					desc_d = head;
					half_d = 1'b0;
					if (head.kind == CMD_LITERAL) begin
						phase_d = SQ_LIT;
						ctx_d   = CTX_TREE;
						lit_d   = head.lit;
					end else if (head.emit_rep) begin
						phase_d = SQ_REP;
					end else if (head.code_ofs) begin
						phase_d = SQ_OFS;
						ctx_d   = CTX_OFFSET;
						val_d   = head.ofs_val;
					end else begin
						phase_d = SQ_LEN;
						ctx_d   = CTX_LENGTH;
						val_d   = head.len_val;
					end
				end
				SQ_LIT: begin
					if (ctx_q[7]) begin
						phase_d = SQ_IDLE;
					end else begin
						ctx_d = {ctx_q[7:0], sel_bit};
						lit_d = {lit_q[6:0], 1'b0};
					end
				end
				SQ_REP: begin
					half_d = 1'b0;
					if (desc_q.code_ofs) begin
						phase_d = SQ_OFS;
						ctx_d   = CTX_OFFSET;
						val_d   = desc_q.ofs_val;
					end else begin
						phase_d = SQ_LEN;
						ctx_d   = CTX_LENGTH;
						val_d   = desc_q.len_val;
					end
				end
				SQ_OFS, SQ_LEN: begin
					if (more) begin
						if (!half_q) begin
							half_d = 1'b1;
						end else begin
							half_d = 1'b0;
							ctx_d  = ctx_q + 9'd2;
							val_d  = {1'b0, val_q[GAMMA_W-1:1]};
						end
					end else if ((phase_q == SQ_OFS) && (desc_q.kind == CMD_MATCH)) begin
						phase_d = SQ_LEN;
						ctx_d   = CTX_LENGTH;
						val_d   = desc_q.len_val;
						half_d  = 1'b0;
					end else begin
						phase_d = SQ_IDLE;
					end
				end
				default: begin
					phase_d = SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SQ_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		desc_q <= desc_d;
		ctx_q  <= ctx_d;
		val_q  <= val_d;
		half_q <= half_d;
		lit_q  <= lit_d;
	end

	// Clearing pass sets every probability to one half after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == CTX_LAST) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Stage 1: the probability read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!step_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctx_s1  <= sel_ctx;
			bit_s1  <= sel_bit;
			last_s1 <= sel_last;
			// Same context as the one being written back this cycle.
			fwd_s1  <= adv && (sel_ctx == ctx_s1);
		end
		if (adv) begin
			last_p_q <= prob_new;
			item_s2  <= '{step_probability: prob_cur, step_bit: bit_s1, last_step: last_s1};
		end
	end

	// Stage 2: adapt the probability toward the coded bit.
	assign prob_cur = fwd_s1 ? last_p_q : rd_data;

	always_comb begin
		if (bit_s1) begin
			delta    = (9'd264 - {1'b0, prob_cur}) >> 4;
			prob_new = prob_cur + delta[PROB_W-1:0];
		end else begin
			delta    = ({1'b0, prob_cur} + 9'd8) >> 4;
			prob_new = prob_cur - delta[PROB_W-1:0];
		end
	end

	assign wr_en   = clearing_q || adv;
	assign wr_addr = clearing_q ? clr_cnt_q : ctx_s1;
	assign wr_data = clearing_q ? PROB_INIT : prob_new;

	lzb_ram #(
		.WIDTH(PROB_W),
		.DEPTH(CTX_COUNT)
	) u_prob_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (issue),
		.rd_addr(sel_ctx),
		.rd_data(rd_data)
	);

	a_last_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		issue && sel_last |=> phase_q == SQ_IDLE)
		else $error("sequencer did not return to idle after the last decision");
	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !pop)
		else $error("decision issued during the clearing pass");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(ctx_s1) && $stable(bit_s1))
		else $error("stalled decision changed in stage 1");

endmodule

`default_nettype wire

// ----- rtl/core/lz_token_context_binarizer_unit.sv -----
// Top level of the LZ token context binarizer.
// Depends on lzb_pkg, lzb_front, lzb_queue and lzb_back (which holds lzb_ram).
//
// The block takes one LZ token per item (literal, match or end of stream) and
// returns one step item per binary decision, each with the 8-bit probability of
// a one bit as it stood before that decision adapted it. The last step of a
// token carries last_step. A literal gives nine steps; a match gives from
// three to sixty-four steps, and an end of stream two or three. Steps leave at
// one per cycle while step_stall is low, a rate set by the read-modify-write of
// the probability RAM, whose single write port takes one update each cycle.
// The front end classifies tokens and hands them through a four-entry queue,
// so a new token is taken while earlier ones are still being sequenced. After
// reset the block writes the initial probability into every context and holds
// token_stall high while it does so. Reset is needed between streams, since
// the probabilities and the repeat-offset state carry over.
`default_nettype none

module lz_token_context_binarizer_unit import lzb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       token_valid,
	output logic            token_stall,
	input  wire lzb_token_t token,
	output logic            step_valid,
	input  wire logic       step_stall,
	output lzb_step_t       step
);

	logic      ready;
	logic      full;
	logic      push;
	lzb_desc_t push_desc;
	logic      pop;
	logic      head_valid;
	lzb_desc_t head;

	// Classification and the repeat-offset bookkeeping.
	lzb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token      (token),
		.ready      (ready),
		.full       (full),
		.push       (push),
		.push_desc  (push_desc)
	);

	// Decouples token intake from the decision stream.
	lzb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// Decision sequencer, probability memory and output register.
	lzb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.ready     (ready),
		.step_valid(step_valid),
		.step_stall(step_stall),
		.step      (step)
	);

endmodule

`default_nettype wire
